### rtl/wcfe_pkg.sv
`timescale 1ns / 1ps

package wcfe_pkg;

  localparam int unsigned NumRows = 9;
  localparam int unsigned RowW    = 11;

  localparam logic [3:0] LastRow = 4'(NumRows - 1);

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_FWD  = 2'd1,
    OP_BACK = 2'd2
  } wcfe_op_t;

  // time after an item, as handed from front to back
  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic       wb;
  } wcfe_time_t;

  localparam logic [RowW-1:0] W_IT_IS    = 11'b00000001111;
  localparam logic [RowW-1:0] W_TO       = 11'b00000011000;
  localparam logic [RowW-1:0] W_MIDNIGHT = 11'b00011111111;
  localparam logic [RowW-1:0] W_ONE_TWO  = 11'b01110000000;
  localparam logic [RowW-1:0] W_THREE    = 11'b11111000000;
  localparam logic [RowW-1:0] W_BEER     = 11'b11110000000;
  localparam logic [RowW-1:0] W_FIVE_HR  = 11'b00011110000;
  localparam logic [RowW-1:0] W_OCLOCK   = 11'b11111100000;
  localparam logic [RowW-1:0] W_QUARTER  = 11'b00001111111;
  localparam logic [RowW-1:0] W_TWENTY   = 11'b11111101111;
  localparam logic [RowW-1:0] W_TEN_MIN  = 11'b00001110000;
  localparam logic [RowW-1:0] W_NOON     = 11'b00111100000;
  localparam logic [RowW-1:0] W_PAST     = 11'b00000001111;
  localparam logic [RowW-1:0] W_FOUR     = 11'b00000001111;
  localparam logic [RowW-1:0] W_FIVE_MIN = 11'b00000001111;
  localparam logic [RowW-1:0] W_SIX      = 11'b11100000000;
  localparam logic [RowW-1:0] W_SEVEN    = 11'b00000011111;
  localparam logic [RowW-1:0] W_EIGHT    = 11'b11111000000;
  localparam logic [RowW-1:0] W_NINE     = 11'b00000111100;
  localparam logic [RowW-1:0] W_TEN_HR   = 11'b00000000111;
  localparam logic [RowW-1:0] W_ELEVEN   = 11'b00000111111;
  localparam logic [RowW-1:0] W_HALF     = 11'b11110000000;

endpackage

### rtl/wcfe_ifs.sv
`timescale 1ns / 1ps

interface wcfe_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [6:0] minute_bcd;
  logic [5:0] hour_bcd;

  modport source (output valid, op, minute_bcd, hour_bcd, input ready);
  modport sink   (input valid, op, minute_bcd, hour_bcd, output ready);
endinterface

interface wcfe_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  row_index;
  logic [10:0] row_bits;
  logic        last;
  logic        write_back;
  logic [5:0]  hour_out_bcd;
  logic [6:0]  minute_out_bcd;

  modport source (output valid, row_index, row_bits, last, write_back, hour_out_bcd,
                  minute_out_bcd, input ready);
  modport sink   (input valid, row_index, row_bits, last, write_back, hour_out_bcd,
                  minute_out_bcd, output ready);
endinterface

### rtl/wcfe_front.sv
`timescale 1ns / 1ps

module wcfe_front (
  input  logic               clk,
  input  logic               rst_n,
  wcfe_in_if.sink            in_ch,
  output logic               push_valid,
  input  logic               push_ready,
  output wcfe_pkg::wcfe_time_t push_data
);

  logic [4:0] hour_r,   hour_nxt;
  logic [5:0] minute_r, minute_nxt;
  logic       wb;
  logic [5:0] h_dec;
  logic [6:0] m_dec;
  logic [9:0] prod;
  logic [3:0] quint;
  logic       accept;

  assign h_dec  = 6'(in_ch.hour_bcd[5:4]) * 6'd10 + 6'(in_ch.hour_bcd[3:0]);
  assign m_dec  = 7'(in_ch.minute_bcd[6:4]) * 7'd10 + 7'(in_ch.minute_bcd[3:0]);
  // minute / 5 via reciprocal, exact for minute < 64
  assign prod   = 10'(minute_r) * 10'd13;
  assign quint  = prod[9:6];
  assign accept = in_ch.valid && push_ready;

  always_comb begin
    hour_nxt   = hour_r;
    minute_nxt = minute_r;
    wb         = 1'b0;
    case (in_ch.op)
      wcfe_pkg::OP_LOAD: begin
        hour_nxt   = (h_dec > 6'd23) ? 5'd23 : h_dec[4:0];
        minute_nxt = (m_dec > 7'd59) ? 6'd59 : m_dec[5:0];
      end
      wcfe_pkg::OP_FWD: begin
        wb = 1'b1;
        if (minute_r > 6'd54) begin
          hour_nxt   = (hour_r == 5'd23) ? 5'd0 : hour_r + 5'd1;
          minute_nxt = 6'd0;
        end else begin
          minute_nxt = 6'({quint, 2'b00} + 6'(quint)) + 6'd5;
        end
      end
      wcfe_pkg::OP_BACK: begin
        wb = 1'b1;
        if (minute_r < 6'd5) begin
          hour_nxt   = (hour_r == 5'd0) ? 5'd23 : hour_r - 5'd1;
          minute_nxt = 6'd55;
        end else begin
          minute_nxt = 6'({quint, 2'b00} + 6'(quint)) - 6'd5;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hour_r   <= 5'd0;
      minute_r <= 6'd0;
    end else if (accept) begin
      hour_r   <= hour_nxt;
      minute_r <= minute_nxt;
    end
  end

  assign in_ch.ready      = push_ready;
  assign push_valid       = in_ch.valid;
  assign push_data.hour   = hour_nxt;
  assign push_data.minute = minute_nxt;
  assign push_data.wb     = wb;

endmodule

### rtl/wcfe_fifo.sv
`timescale 1ns / 1ps

module wcfe_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push_valid,
  output logic                 push_ready,
  input  wcfe_pkg::wcfe_time_t push_data,
  output logic                 pop_valid,
  input  logic                 pop_ready,
  output wcfe_pkg::wcfe_time_t pop_data
);

  wcfe_pkg::wcfe_time_t mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  logic       push, pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule

### rtl/wcfe_back.sv
`timescale 1ns / 1ps

module wcfe_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 pop_valid,
  output logic                 pop_ready,
  input  wcfe_pkg::wcfe_time_t pop_data,
  wcfe_out_if.source           out_ch
);

  wcfe_pkg::wcfe_time_t entry_r;
  logic        have_r;
  logic [3:0]  row_r;
  logic        out_valid_r;
  logic [3:0]  out_row_r;
  logic [10:0] out_bits_r;
  logic        out_last_r;
  logic        out_wb_r;
  logic [5:0]  out_hour_r;
  logic [6:0]  out_min_r;

  logic [10:0] rows [wcfe_pkg::NumRows];
  logic [4:0]  h;
  logic [5:0]  m;
  logic        advance, run_end;
  logic [5:0]  hour_bcd;
  logic [6:0]  min_bcd;
  logic [1:0]  h_tens;
  logic [2:0]  m_tens;

  assign m = entry_r.minute;

  always_comb begin
    for (int i = 0; i < wcfe_pkg::NumRows; i++) begin
      rows[i] = '0;
    end
    rows[0] = wcfe_pkg::W_IT_IS;
    h = entry_r.hour;
    if (m > 6'd4 && m < 6'd35) begin
      rows[3] = wcfe_pkg::W_PAST;
    end else if (m > 6'd34) begin
      rows[3] = wcfe_pkg::W_TO;
      h = (entry_r.hour == 5'd23) ? 5'd0 : entry_r.hour + 5'd1;
    end
    case (h)
      5'd0: rows[6] = wcfe_pkg::W_MIDNIGHT;
      5'd1, 5'd13: rows[7] = wcfe_pkg::W_ONE_TWO;
      5'd2, 5'd14: rows[6] = wcfe_pkg::W_ONE_TWO;
      5'd3, 5'd15: rows[4] = wcfe_pkg::W_THREE;
      5'd4, 5'd16: rows[5] = wcfe_pkg::W_FOUR;
      5'd5, 5'd17: begin
        if (entry_r.hour == 5'd17 && m < 6'd5) begin
          rows[2] = wcfe_pkg::W_BEER;
        end else begin
          rows[5] = wcfe_pkg::W_FIVE_HR;
        end
      end
      5'd6, 5'd18: rows[5] = wcfe_pkg::W_SIX;
      5'd7, 5'd19: rows[8] = wcfe_pkg::W_SEVEN;
      5'd8, 5'd20: rows[3] = rows[3] | wcfe_pkg::W_EIGHT;
      5'd9, 5'd21: rows[4] = wcfe_pkg::W_NINE;
      5'd10, 5'd22: rows[4] = wcfe_pkg::W_TEN_HR;
      5'd11, 5'd23: rows[7] = wcfe_pkg::W_ELEVEN;
      5'd12: rows[7] = wcfe_pkg::W_NOON;
      default: begin
      end
    endcase
    if (m < 6'd5 && h != 5'd12 && h != 5'd0) begin
      rows[8] = rows[8] | wcfe_pkg::W_OCLOCK;
    end else if ((m > 6'd4 && m < 6'd10) || m > 6'd54) begin
      rows[2] = wcfe_pkg::W_FIVE_MIN;
    end else if ((m > 6'd9 && m < 6'd15) || (m > 6'd49 && m < 6'd55)) begin
      rows[2] = wcfe_pkg::W_TEN_MIN;
    end else if ((m > 6'd14 && m < 6'd20) || (m > 6'd44 && m < 6'd50)) begin
      rows[1] = wcfe_pkg::W_QUARTER;
    end else if ((m > 6'd19 && m < 6'd25) || (m > 6'd39 && m < 6'd45)) begin
      rows[0] = wcfe_pkg::W_TWENTY;
    end else if ((m > 6'd24 && m < 6'd30) || (m > 6'd34 && m < 6'd40)) begin
      rows[0] = wcfe_pkg::W_TWENTY;
      rows[2] = wcfe_pkg::W_FIVE_MIN;
    end else if (m > 6'd29 && m < 6'd35) begin
      rows[1] = wcfe_pkg::W_HALF;
    end
  end

  // BCD for the clock chip, values known to be below 24 and 60
  always_comb begin
    h_tens = (entry_r.hour >= 5'd20) ? 2'd2 : (entry_r.hour >= 5'd10) ? 2'd1 : 2'd0;
    if (m >= 6'd50) begin
      m_tens = 3'd5;
    end else if (m >= 6'd40) begin
      m_tens = 3'd4;
    end else if (m >= 6'd30) begin
      m_tens = 3'd3;
    end else if (m >= 6'd20) begin
      m_tens = 3'd2;
    end else if (m >= 6'd10) begin
      m_tens = 3'd1;
    end else begin
      m_tens = 3'd0;
    end
    hour_bcd = {h_tens, 4'(entry_r.hour - 5'(h_tens) * 5'd10)};
    min_bcd  = {m_tens, 4'(m - 6'(m_tens) * 6'd10)};
  end

  assign advance   = !out_valid_r || out_ch.ready;
  assign run_end   = have_r && (row_r == wcfe_pkg::LastRow);
  assign pop_ready = advance && (run_end || !have_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r      <= 1'b0;
      row_r       <= 4'd0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= have_r;
      if (!have_r || run_end) begin
        have_r <= pop_valid;
        row_r  <= 4'd0;
      end else begin
        row_r <= row_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop_valid && pop_ready) begin
      entry_r <= pop_data;
    end
    if (advance && have_r) begin
      out_row_r  <= row_r;
      out_bits_r <= rows[row_r];
      out_last_r <= (row_r == wcfe_pkg::LastRow);
      out_wb_r   <= entry_r.wb;
      out_hour_r <= hour_bcd;
      out_min_r  <= min_bcd;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.row_index      = out_row_r;
  assign out_ch.row_bits       = out_bits_r;
  assign out_ch.last           = out_last_r;
  assign out_ch.write_back     = out_wb_r;
  assign out_ch.hour_out_bcd   = out_hour_r;
  assign out_ch.minute_out_bcd = out_min_r;

`ifndef SYNTH
  a_row_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_ch.ready && !out_last_r |=>
      out_valid_r && out_row_r == $past(out_row_r) + 4'd1)
    else $error("row sequence broken inside a run");

  a_run_time_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_ch.ready && !out_last_r |=>
      $stable(out_hour_r) && $stable(out_min_r) && $stable(out_wb_r))
    else $error("time changed inside a run");

  a_run_starts: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_ch.ready && out_last_r |=>
      !out_valid_r || out_row_r == 4'd0)
    else $error("run did not start at row zero");

  a_last_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_last_r == (out_row_r == wcfe_pkg::LastRow)))
    else $error("last flag off the final row");
`endif

endmodule

### rtl/word_clock_face_encoder.sv
`timescale 1ns / 1ps

// Word clock face encoder.
// in_ch: one beat per command (BCD load, one 5-min mark forward or back, no-op).
// out_ch: nine beats per command, rows 0..8 of the LED grid in order, last on row 8.
//   Every beat also carries write_back and the current time in BCD.
// The front updates the time and writes it into a two-entry queue; the back
// loads the queue head into its entry register and renders its rows into an
// output register, one row per cycle while out_ch.ready allows; the single
// result channel carries one command's rows at a time, and up to two commands
// can wait in the queue.
// Reset: synchronous, active low; time returns to 00:00, queue and output
// register empty, no beat pending.
// Stall: when out_ch.ready is low the row held in the output register stays;
// the front keeps taking commands until the queue is full, then drops in_ch.ready.
module word_clock_face_encoder (
  input  logic        clk,
  input  logic        rst_n,
  wcfe_in_if.sink     in_ch,
  wcfe_out_if.source  out_ch
);

  logic                 push_valid, push_ready;
  logic                 pop_valid, pop_ready;
  wcfe_pkg::wcfe_time_t push_data, pop_data;

  wcfe_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  wcfe_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  wcfe_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_ch    (out_ch)
  );

endmodule

### sim/word_clock_face_encoder_test.sv
`timescale 1ns / 1ps

module word_clock_face_encoder_test;

  localparam logic [1:0] OpIdle     = 2'd3;
  localparam int         CycleLimit = 400000;
  localparam int         MaxReports = 10;

  typedef logic [wcfe_pkg::NumRows-1:0][wcfe_pkg::RowW-1:0] face_t;

  typedef struct packed {
    logic [3:0]                row_index;
    logic [wcfe_pkg::RowW-1:0] row_bits;
    logic                      last;
    logic                      wb;
    logic [5:0]                hour_bcd;
    logic [6:0]                minute_bcd;
  } face_beat_t;

  // typed = 1: hour/minute/write-back of every row are given by hand
  typedef struct packed {
    logic [1:0] op;
    logic [6:0] mb;
    logic [5:0] hb;
    logic       typed;
    logic [5:0] hq;
    logic [6:0] mq;
    logic       wq;
  } clock_cmd_t;

  logic clk;
  logic rst_n;

  wcfe_in_if  in_ch ();
  wcfe_out_if out_ch ();

  word_clock_face_encoder DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  logic [4:0]  clock_hour;
  logic [5:0]  clock_min;
  face_beat_t  face_q[$];
  face_beat_t  want;
  int          error_cnt;
  int          cycle_cnt;
  int          sink_hold;
  bit          calm;

  clock_cmd_t dir_tab [25] = '{
    '{wcfe_pkg::OP_FWD,  7'h00, 6'h00, 1'b1, 6'h00, 7'h05, 1'b1},
    '{wcfe_pkg::OP_BACK, 7'h00, 6'h00, 1'b1, 6'h00, 7'h00, 1'b1},
    '{wcfe_pkg::OP_BACK, 7'h00, 6'h00, 1'b1, 6'h23, 7'h55, 1'b1},
    '{wcfe_pkg::OP_FWD,  7'h00, 6'h00, 1'b1, 6'h00, 7'h00, 1'b1},
    '{wcfe_pkg::OP_LOAD, 7'h59, 6'h23, 1'b1, 6'h23, 7'h59, 1'b0},
    '{wcfe_pkg::OP_FWD,  7'h00, 6'h00, 1'b1, 6'h00, 7'h00, 1'b1},
    '{wcfe_pkg::OP_LOAD, 7'h7F, 6'h3F, 1'b1, 6'h23, 7'h59, 1'b0},
    '{wcfe_pkg::OP_LOAD, 7'h00, 6'h00, 1'b1, 6'h00, 7'h00, 1'b0},
    '{wcfe_pkg::OP_LOAD, 7'h00, 6'h12, 1'b1, 6'h12, 7'h00, 1'b0},
    '{wcfe_pkg::OP_LOAD, 7'h03, 6'h17, 1'b1, 6'h17, 7'h03, 1'b0},
    '{wcfe_pkg::OP_LOAD, 7'h04, 6'h17, 1'b0, 6'h00, 7'h00, 1'b0},
    '{wcfe_pkg::OP_FWD,  7'h00, 6'h00, 1'b1, 6'h17, 7'h05, 1'b1},
    '{OpIdle,            7'h7F, 6'h3F, 1'b1, 6'h17, 7'h05, 1'b0},
    '{wcfe_pkg::OP_LOAD, 7'h35, 6'h16, 1'b0, 6'h00, 7'h00, 1'b0},
    '{wcfe_pkg::OP_LOAD, 7'h40, 6'h07, 1'b0, 6'h00, 7'h00, 1'b0},
    '{wcfe_pkg::OP_LOAD, 7'h00, 6'h07, 1'b0, 6'h00, 7'h00, 1'b0},
    '{wcfe_pkg::OP_LOAD, 7'h22, 6'h09, 1'b0, 6'h00, 7'h00, 1'b0},
    '{wcfe_pkg::OP_LOAD, 7'h27, 6'h10, 1'b0, 6'h00, 7'h00, 1'b0},
    '{wcfe_pkg::OP_LOAD, 7'h30, 6'h11, 1'b0, 6'h00, 7'h00, 1'b0},
    '{wcfe_pkg::OP_LOAD, 7'h15, 6'h13, 1'b0, 6'h00, 7'h00, 1'b0},
    '{wcfe_pkg::OP_LOAD, 7'h12, 6'h14, 1'b0, 6'h00, 7'h00, 1'b0},
    '{wcfe_pkg::OP_LOAD, 7'h55, 6'h23, 1'b0, 6'h00, 7'h00, 1'b0},
    '{wcfe_pkg::OP_LOAD, 7'h0A, 6'h0F, 1'b1, 6'h15, 7'h10, 1'b0},
    '{wcfe_pkg::OP_LOAD, 7'h34, 6'h11, 1'b0, 6'h00, 7'h00, 1'b0},
    '{wcfe_pkg::OP_LOAD, 7'h58, 6'h11, 1'b0, 6'h00, 7'h00, 1'b0}
  };

  always #5 clk = ~clk;

  function automatic logic [7:0] bcd_of(input int v);
    return 8'(((v / 10) << 4) | (v % 10));
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return 0;
    if (r < 9) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  function automatic face_t render_face(input logic [4:0] hr, input logic [5:0] mn);
    face_t f;
    int    h;
    int    m;
    f = '0;
    h = hr;
    m = mn;
    f[0] = wcfe_pkg::W_IT_IS;
    if (m > 4 && m < 35) begin
      f[3] = wcfe_pkg::W_PAST;
    end else if (m > 34) begin
      f[3] = wcfe_pkg::W_TO;
      h = (h + 1) % 24;
    end
    case (h)
      0:      f[6] = wcfe_pkg::W_MIDNIGHT;
      1, 13:  f[7] = wcfe_pkg::W_ONE_TWO;
      2, 14:  f[6] = wcfe_pkg::W_ONE_TWO;
      3, 15:  f[4] = wcfe_pkg::W_THREE;
      4, 16:  f[5] = wcfe_pkg::W_FOUR;
      5, 17: begin
        if (hr == 5'd17 && mn < 6'd5) f[2] = wcfe_pkg::W_BEER;
        else f[5] = wcfe_pkg::W_FIVE_HR;
      end
      6, 18:  f[5] = wcfe_pkg::W_SIX;
      7, 19:  f[8] = wcfe_pkg::W_SEVEN;
      8, 20:  f[3] = f[3] | wcfe_pkg::W_EIGHT;
      9, 21:  f[4] = wcfe_pkg::W_NINE;
      10, 22: f[4] = wcfe_pkg::W_TEN_HR;
      11, 23: f[7] = wcfe_pkg::W_ELEVEN;
      12:     f[7] = wcfe_pkg::W_NOON;
      default: ;
    endcase
    if (m < 5 && h != 12 && h != 0) begin
      f[8] = f[8] | wcfe_pkg::W_OCLOCK;
    end else if ((m > 4 && m < 10) || m > 54) begin
      f[2] = wcfe_pkg::W_FIVE_MIN;
    end else if ((m > 9 && m < 15) || (m > 49 && m < 55)) begin
      f[2] = wcfe_pkg::W_TEN_MIN;
    end else if ((m > 14 && m < 20) || (m > 44 && m < 50)) begin
      f[1] = wcfe_pkg::W_QUARTER;
    end else if ((m > 19 && m < 25) || (m > 39 && m < 45)) begin
      f[0] = wcfe_pkg::W_TWENTY;
    end else if ((m > 24 && m < 30) || (m > 34 && m < 40)) begin
      f[0] = wcfe_pkg::W_TWENTY;
      f[2] = wcfe_pkg::W_FIVE_MIN;
    end else if (m > 29 && m < 35) begin
      f[1] = wcfe_pkg::W_HALF;
    end
    return f;
  endfunction

  task automatic advance_clock(input clock_cmd_t c);
    int         h;
    int         m;
    int         r;
    logic       wb;
    face_t      f;
    face_beat_t b;
    wb = 1'b0;
    case (c.op)
      wcfe_pkg::OP_LOAD: begin
        h = c.hb[5:4] * 10 + c.hb[3:0];
        m = c.mb[6:4] * 10 + c.mb[3:0];
        clock_hour = 5'((h > 23) ? 23 : h);
        clock_min  = 6'((m > 59) ? 59 : m);
      end
      wcfe_pkg::OP_FWD: begin
        if (clock_min > 6'd54) begin
          clock_hour = 5'((clock_hour + 1) % 24);
          clock_min  = '0;
        end else begin
          clock_min = 6'((clock_min / 5 + 1) * 5);
        end
        wb = 1'b1;
      end
      wcfe_pkg::OP_BACK: begin
        if (clock_min < 6'd5) begin
          clock_hour = 5'((clock_hour + 23) % 24);
          clock_min  = 6'd55;
        end else begin
          clock_min = 6'((clock_min / 5 - 1) * 5);
        end
        wb = 1'b1;
      end
      default: ;
    endcase
    f = render_face(clock_hour, clock_min);
    for (r = 0; r < wcfe_pkg::NumRows; r++) begin
      b.row_index  = 4'(r);
      b.row_bits   = f[r];
      b.last       = (r == wcfe_pkg::NumRows - 1);
      b.wb         = c.typed ? c.wq : wb;
      b.hour_bcd   = c.typed ? c.hq : 6'(bcd_of(clock_hour));
      b.minute_bcd = c.typed ? c.mq : 7'(bcd_of(clock_min));
      face_q.push_back(b);
    end
  endtask

  task automatic send_cmd(input clock_cmd_t c);
    int gap;
    gap = calm ? 0 : idle_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.op         <= c.op;
    in_ch.minute_bcd <= c.mb;
    in_ch.hour_bcd   <= c.hb;
    do @(posedge clk); while (!in_ch.ready);
    advance_clock(c);
  endtask

  // result side back-pressure
  always @(posedge clk) begin
    if (sink_hold != 0) begin
      sink_hold--;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      out_ch.ready <= 1'b0;
      sink_hold = idle_len();
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (face_q.size() == 0) begin
        error_cnt++;
        if (error_cnt <= MaxReports)
          $display("unexpected beat: row %0d bits %b", out_ch.row_index, out_ch.row_bits);
      end else begin
        want = face_q.pop_front();
        if (out_ch.row_index !== want.row_index || out_ch.row_bits !== want.row_bits ||
            out_ch.last !== want.last || out_ch.write_back !== want.wb ||
            out_ch.hour_out_bcd !== want.hour_bcd ||
            out_ch.minute_out_bcd !== want.minute_bcd) begin
          error_cnt++;
          if (error_cnt <= MaxReports)
            $display(
              "mismatch: exp row %0d %b last %b wb %b %h:%h, got row %0d %b last %b wb %b %h:%h",
              want.row_index, want.row_bits, want.last, want.wb, want.hour_bcd,
              want.minute_bcd, out_ch.row_index, out_ch.row_bits, out_ch.last,
              out_ch.write_back, out_ch.hour_out_bcd, out_ch.minute_out_bcd);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("timeout, %0d rows outstanding", face_q.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    clock_cmd_t c;
    int         i;
    int         k;
    int         r;
    clk              = 1'b0;
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.op         = wcfe_pkg::OP_LOAD;
    in_ch.minute_bcd = '0;
    in_ch.hour_bcd   = '0;
    out_ch.ready     = 1'b0;
    clock_hour       = '0;
    clock_min        = '0;
    error_cnt        = 0;
    cycle_cnt        = 0;
    sink_hold        = 0;
    calm             = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < $size(dir_tab); i++)
      send_cmd(dir_tab[i]);

    for (k = 0; k < 5; k++) begin
      calm = ($urandom_range(0, 3) == 0);
      for (i = 0; i < 20; i++) begin
        r       = $urandom_range(0, 99);
        c       = '0;
        c.mb    = 7'($urandom_range(0, 127));
        c.hb    = 6'($urandom_range(0, 63));
        if (r < 30) begin
          c.op = wcfe_pkg::OP_LOAD;
          c.hb = 6'(bcd_of($urandom_range(0, 23)));
          c.mb = 7'(bcd_of($urandom_range(0, 59)));
        end else if (r < 40) begin
          c.op = wcfe_pkg::OP_LOAD;
        end else if (r < 68) begin
          c.op = wcfe_pkg::OP_FWD;
        end else if (r < 92) begin
          c.op = wcfe_pkg::OP_BACK;
        end else begin
          c.op = OpIdle;
        end
        send_cmd(c);
      end
    end
    in_ch.valid <= 1'b0;
    calm = 1'b0;

    while (face_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (face_q.size() != 0) begin
      error_cnt += face_q.size();
      $display("%0d rows never arrived", face_q.size());
    end

    if (error_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
